// ===== hw/rtl/pvagc_pkg.sv =====
// Shared constants, register codes and helpers of the peak/valley envelope normalizer.
// Used by every module of the block; depends on nothing else.
package pvagc_pkg;

   // Sample and envelope formats.
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int ENV_SHIFT            = 16;
   localparam int ENV_ONE              = 268435456;
   localparam int ENV_HALF_LSB         = 32768;

   // Gain format: unsigned Q1.16, one is 65536.
   localparam int GAIN_WIDTH = 17;
   localparam int GAIN_ONE   = 65536;

   // Result format.
   localparam int OUT_WIDTH   = 16;
   localparam int OUT_FRAC    = 12;
   localparam int LEVEL_LIMIT = 20480;
   localparam int QUOT_BITS   = 15;

   // Queue between the envelope tracker and the divider.
   localparam int QUEUE_DEPTH = 2;

   // Register map.
   localparam int               CSR_INDEX_WIDTH = 2;
   localparam logic [1:0]       CSR_ATTACK_GAIN = 2'd0;
   localparam logic [1:0]       CSR_DECAY_GAIN  = 2'd1;
   localparam logic [16:0]      ATTACK_RESET    = 17'd32768;
   localparam logic [16:0]      DECAY_RESET     = 17'd64;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0] attack;
      logic [GAIN_WIDTH-1:0] decay;
   } gain_cfg_type;

   // The envelope must hold the sample range and the reset value of one.
   function automatic int env_width(input int sample_width);
      return ((sample_width > 14) ? sample_width : 14) + ENV_SHIFT;
   endfunction

   // A gain above one acts as one.
   function automatic logic [GAIN_WIDTH-1:0] clamp_gain(input logic [GAIN_WIDTH-1:0] g);
      return (g > GAIN_WIDTH'(GAIN_ONE)) ? GAIN_WIDTH'(GAIN_ONE) : g;
   endfunction

endpackage

// ===== hw/rtl/pvagc_queue.sv =====
// Small ready/valid queue that decouples the envelope tracker from the divider.
// Depth comes from pvagc_pkg; data width is a parameter.
module pvagc_queue #(
   parameter int DATA_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int DEPTH = pvagc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/pvagc_front.sv =====
// Front end: accepts samples, chooses the gains and updates both envelopes with a
// shared shift-add multiply sequence. Depends on pvagc_pkg.
module pvagc_front #(
   parameter int SAMPLE_WIDTH = pvagc_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int ENV_WIDTH    = pvagc_pkg::env_width(pvagc_pkg::SAMPLE_WIDTH_DEFAULT)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pvagc_pkg::gain_cfg_type        gains,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           push_valid,
   input  logic                           push_ready,
   output logic signed [SAMPLE_WIDTH-1:0] push_sample,
   output logic signed [ENV_WIDTH-1:0]    push_peak,
   output logic signed [ENV_WIDTH-1:0]    push_valley
);

   localparam int GW    = pvagc_pkg::GAIN_WIDTH;
   localparam int DW    = ENV_WIDTH + 1;
   localparam int PW    = ENV_WIDTH + 18;
   localparam int CW    = $clog2(GW);
   localparam int SHIFT = pvagc_pkg::ENV_SHIFT;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   localparam logic signed [ENV_WIDTH-1:0] ENV_ONE  = ENV_WIDTH'(pvagc_pkg::ENV_ONE);
   localparam logic signed [PW-1:0]        ROUND_HALF = PW'(pvagc_pkg::ENV_HALF_LSB);

   logic [1:0]                     state_ff, state_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic signed [DW-1:0]           diff_p_ff, diff_p_in, diff_v_ff, diff_v_in;
   logic [GW-1:0]                  gain_p_ff, gain_p_in, gain_v_ff, gain_v_in;
   logic signed [PW-1:0]           acc_p_ff, acc_p_in, acc_v_ff, acc_v_in;
   logic signed [ENV_WIDTH-1:0]    peak_ff, peak_in, valley_ff, valley_in;

   logic signed [ENV_WIDTH-1:0]    xe;
   logic [GW-1:0]                  ga, gd;
   logic signed [PW-1:0]           rnd_p, rnd_v, step_p, step_v;
   logic signed [ENV_WIDTH-1:0]    new_peak, new_valley;

   assign req_ready  = (state_ff == ST_IDLE);
   assign push_valid = (state_ff == ST_PUSH);

   // Incoming sample on the envelope scale and the clamped gains.
   assign xe = ENV_WIDTH'(req_sample) <<< SHIFT;
   assign ga = pvagc_pkg::clamp_gain(gains.attack);
   assign gd = pvagc_pkg::clamp_gain(gains.decay);

   // Round the products and apply the steps to the envelopes.
   assign rnd_p      = acc_p_ff + ROUND_HALF;
   assign rnd_v      = acc_v_ff + ROUND_HALF;
   assign step_p     = rnd_p >>> SHIFT;
   assign step_v     = rnd_v >>> SHIFT;
   assign new_peak   = peak_ff + step_p[ENV_WIDTH-1:0];
   assign new_valley = valley_ff + step_v[ENV_WIDTH-1:0];

   assign push_sample = sample_ff;
   assign push_peak   = new_peak;
   assign push_valley = new_valley;

   // Sequencer: accept, multiply one gain bit per cycle, then hand off.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sample_in = sample_ff;
      diff_p_in = diff_p_ff;
      diff_v_in = diff_v_ff;
      gain_p_in = gain_p_ff;
      gain_v_in = gain_v_ff;
      acc_p_in  = acc_p_ff;
      acc_v_in  = acc_v_ff;
      peak_in   = peak_ff;
      valley_in = valley_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               diff_p_in = DW'(xe) - DW'(peak_ff);
               diff_v_in = DW'(xe) - DW'(valley_ff);
               gain_p_in = (xe >= peak_ff) ? ga : gd;
               gain_v_in = (xe < valley_ff) ? ga : gd;
               acc_p_in  = '0;
               acc_v_in  = '0;
               cnt_in    = CW'(GW - 1);
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_p_in = (acc_p_ff <<< 1) + (gain_p_ff[cnt_ff] ? PW'(diff_p_ff) : '0);
            acc_v_in = (acc_v_ff <<< 1) + (gain_v_ff[cnt_ff] ? PW'(diff_v_ff) : '0);
            if (cnt_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_PUSH: begin
            if (push_ready) begin
               peak_in   = new_peak;
               valley_in = new_valley;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and the envelopes.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         peak_ff   <= ENV_ONE;
         valley_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         peak_ff   <= peak_in;
         valley_ff <= valley_in;
      end
   end

   // Working registers of the multiply.
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      diff_p_ff <= diff_p_in;
      diff_v_ff <= diff_v_in;
      gain_p_ff <= gain_p_in;
      gain_v_ff <= gain_v_in;
      acc_p_ff  <= acc_p_in;
      acc_v_ff  <= acc_v_in;
   end

endmodule

// ===== hw/rtl/pvagc_back.sv =====
// Back end: forms the normalized level with a restoring divider and holds the
// result beat in an output register. Depends on pvagc_pkg.
module pvagc_back #(
   parameter int SAMPLE_WIDTH = pvagc_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int ENV_WIDTH    = pvagc_pkg::env_width(pvagc_pkg::SAMPLE_WIDTH_DEFAULT)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] pop_sample,
   input  logic signed [ENV_WIDTH-1:0]    pop_peak,
   input  logic signed [ENV_WIDTH-1:0]    pop_valley,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [pvagc_pkg::OUT_WIDTH-1:0] rsp_level,
   output logic signed [pvagc_pkg::OUT_WIDTH-1:0] rsp_peak_level,
   output logic signed [pvagc_pkg::OUT_WIDTH-1:0] rsp_valley_level,
   output logic                           rsp_span_empty
);

   localparam int OW    = pvagc_pkg::OUT_WIDTH;
   localparam int QB    = pvagc_pkg::QUOT_BITS;
   localparam int QCW   = $clog2(QB);
   localparam int SHIFT = pvagc_pkg::ENV_SHIFT;
   localparam int NW    = ENV_WIDTH + 2;
   localparam int SPW   = ENV_WIDTH + 1;
   localparam int RW    = ENV_WIDTH + 17;
   localparam int LW    = ENV_WIDTH + 1 - SHIFT;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [QB-1:0]        Q_LIMIT   = QB'(pvagc_pkg::LEVEL_LIMIT);
   localparam logic signed [OW-1:0] LEVEL_POS = OW'(pvagc_pkg::LEVEL_LIMIT);
   localparam logic signed [OW-1:0] LEVEL_NEG = -OW'(pvagc_pkg::LEVEL_LIMIT);

   // Round an envelope to the output format and saturate it.
   function automatic logic signed [OW-1:0] env_round(input logic signed [ENV_WIDTH-1:0] env);
      logic signed [ENV_WIDTH:0] biased;
      logic signed [LW-1:0]      r;
      biased = (ENV_WIDTH + 1)'(env) + (ENV_WIDTH + 1)'(pvagc_pkg::ENV_HALF_LSB);
      r      = biased[ENV_WIDTH:SHIFT];
      if (r > 32'sd32767) begin
         return {1'b0, {(OW - 1){1'b1}}};
      end else if (r < -32'sd32768) begin
         return {1'b1, {(OW - 1){1'b0}}};
      end
      return OW'(r);
   endfunction

   logic [1:0]              state_ff, state_in;
   logic [QCW-1:0]          cnt_ff, cnt_in;
   logic signed [NW-1:0]    num_ff, num_in;
   logic [SPW-1:0]          span_ff, span_in;
   logic                    empty_ff, empty_in;
   logic signed [OW-1:0]    peak_lvl_ff, peak_lvl_in, valley_lvl_ff, valley_lvl_in;
   logic                    neg_ff, neg_in, sat_ff, sat_in;
   logic [RW-1:0]           rem_ff, rem_in, dv_ff, dv_in;
   logic [QB-1:0]           q_ff, q_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0]    rsp_level_ff, rsp_level_in;
   logic signed [OW-1:0]    rsp_peak_ff, rsp_peak_in, rsp_valley_ff, rsp_valley_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   logic signed [ENV_WIDTH-1:0] xe;
   logic [NW-1:0]           mag;
   logic [RW-1:0]           dividend, divisor;
   logic                    rem_ge;
   logic [QB-1:0]           q_sat;
   logic                    out_free;

   assign pop_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign xe       = ENV_WIDTH'(pop_sample) <<< SHIFT;
   assign mag      = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
   assign dividend = (RW'(mag) << pvagc_pkg::OUT_FRAC) + RW'(span_ff);
   assign divisor  = RW'(span_ff) << 1;
   assign rem_ge   = (rem_ff >= dv_ff);
   assign q_sat    = (sat_ff || (q_ff > Q_LIMIT)) ? Q_LIMIT : q_ff;

   // Sequencer: take an entry, set up the division, one quotient bit per cycle.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      num_in        = num_ff;
      span_in       = span_ff;
      empty_in      = empty_ff;
      peak_lvl_in   = peak_lvl_ff;
      valley_lvl_in = valley_lvl_ff;
      neg_in        = neg_ff;
      sat_in        = sat_ff;
      rem_in        = rem_ff;
      dv_in         = dv_ff;
      q_in          = q_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_level_in  = rsp_level_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_valley_in = rsp_valley_ff;
      rsp_empty_in  = rsp_empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               num_in        = (NW'(xe) <<< 1) - NW'(pop_peak) - NW'(pop_valley);
               span_in       = SPW'(pop_peak) - SPW'(pop_valley);
               empty_in      = !(pop_peak > pop_valley);
               peak_lvl_in   = env_round(pop_peak);
               valley_lvl_in = env_round(pop_valley);
               state_in      = ST_PREP;
            end
         end
         ST_PREP: begin
            // A dividend at or above the divisor times 2^15 is far past the limit.
            neg_in   = num_ff[NW-1];
            rem_in   = dividend;
            sat_in   = (dividend >= (divisor << QB));
            dv_in    = divisor << (QB - 1);
            q_in     = '0;
            cnt_in   = QCW'(QB - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ge) begin
               rem_in = rem_ff - dv_ff;
            end
            q_in  = {q_ff[QB-2:0], rem_ge};
            dv_in = dv_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_peak_in   = peak_lvl_ff;
               rsp_valley_in = valley_lvl_ff;
               rsp_empty_in  = empty_ff;
               if (empty_ff) begin
                  rsp_level_in = '0;
               end else if (neg_ff) begin
                  rsp_level_in = -OW'(q_sat);
               end else begin
                  rsp_level_in = OW'(q_sat);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Divider working registers and the output beat.
   always_ff @(posedge clock) begin
      num_ff        <= num_in;
      span_ff       <= span_in;
      empty_ff      <= empty_in;
      peak_lvl_ff   <= peak_lvl_in;
      valley_lvl_ff <= valley_lvl_in;
      neg_ff        <= neg_in;
      sat_ff        <= sat_in;
      rem_ff        <= rem_in;
      dv_ff         <= dv_in;
      q_ff          <= q_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_valley_ff <= rsp_valley_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_peak_level   = rsp_peak_ff;
   assign rsp_valley_level = rsp_valley_ff;
   assign rsp_span_empty   = rsp_empty_ff;

`ifndef ASSERT_OFF
   // An empty span always reports a zero level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_level_ff == '0)
      else $error("level not zero on empty span");

   // The level never leaves the saturation window.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= LEVEL_POS) && (rsp_level_ff >= LEVEL_NEG))
      else $error("level outside saturation window");

   // The divider only runs on or finishes.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |=> state_ff == ST_DIV || state_ff == ST_DONE)
      else $error("divider left its sequence early");

   // A finished result with a free output register is presented next cycle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !rsp_valid_ff |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished result not presented");
`endif

endmodule

// ===== hw/rtl/peak_valley_agc_normalizer.sv =====
// Top level of the peak/valley envelope normalizer: gain registers, envelope front end,
// hand-off queue and divider back end. Depends on pvagc_pkg, pvagc_front, pvagc_queue,
// pvagc_back.
//
//   Channel   Direction  Handshake                     Payload
//   req_      in         req_valid / req_ready         req_sample
//   rsp_      out        rsp_valid / rsp_ready         rsp_level, rsp_peak_level,
//                                                      rsp_valley_level, rsp_span_empty
//   csr_      in         csr_write_enable (no wait)    csr_index, csr_wdata
//
// The front end handles one sample at a time: it accepts it, runs the bit-serial gain
// multiply (one gain bit per cycle), then updates the envelopes and hands off.
// The back end captures an entry, sets up the division, forms 15 quotient bits and outputs.
// The front end paces the block: it takes a new sample only after handing off the last.
// Reset is synchronous: gains return to 32768 and 64, peak to 1.0 and valley to 0.
// A two-entry queue and the output register let either side stall without the other.
module peak_valley_agc_normalizer #(
   parameter int SAMPLE_WIDTH = pvagc_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pvagc_pkg::OUT_WIDTH-1:0] rsp_level,
   output logic signed [pvagc_pkg::OUT_WIDTH-1:0] rsp_peak_level,
   output logic signed [pvagc_pkg::OUT_WIDTH-1:0] rsp_valley_level,
   output logic                                   rsp_span_empty,
   input  logic                                   csr_write_enable,
   input  logic [pvagc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pvagc_pkg::GAIN_WIDTH-1:0]       csr_wdata
);

   localparam int EW = pvagc_pkg::env_width(SAMPLE_WIDTH);
   localparam int QW = SAMPLE_WIDTH + 2 * EW;

   pvagc_pkg::gain_cfg_type gains_ff, gains_in;

   logic                           push_valid, push_ready, pop_valid, pop_ready;
   logic signed [SAMPLE_WIDTH-1:0] push_sample, pop_sample;
   logic signed [EW-1:0]           push_peak, push_valley, pop_peak, pop_valley;
   logic [QW-1:0]                  push_data, pop_data;

   // Gain registers; writes to unused indexes are dropped.
   always_comb begin
      gains_in = gains_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pvagc_pkg::CSR_ATTACK_GAIN: gains_in.attack = csr_wdata;
            pvagc_pkg::CSR_DECAY_GAIN:  gains_in.decay  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.attack <= pvagc_pkg::ATTACK_RESET;
         gains_ff.decay  <= pvagc_pkg::DECAY_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

   pvagc_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ENV_WIDTH    (EW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .gains       (gains_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_sample (push_sample),
      .push_peak   (push_peak),
      .push_valley (push_valley)
   );

   // Pack the sample and both envelopes for the queue.
   assign push_data = {push_sample, push_peak, push_valley};

   pvagc_queue #(
      .DATA_WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_sample = pop_data[QW-1 -: SAMPLE_WIDTH];
   assign pop_peak   = pop_data[2*EW-1 -: EW];
   assign pop_valley = pop_data[EW-1:0];

   pvagc_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ENV_WIDTH    (EW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_sample       (pop_sample),
      .pop_peak         (pop_peak),
      .pop_valley       (pop_valley),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_level        (rsp_level),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_valley_level (rsp_valley_level),
      .rsp_span_empty   (rsp_span_empty)
   );

endmodule
